// ===== hdl/psfp_pkg.sv =====
// Shared types and constants of the particle sensor frame parser.
package psfp_pkg;

  localparam logic [7:0] START_BYTE_A = 8'h42;
  localparam logic [7:0] START_BYTE_B = 8'h4D;
  localparam int unsigned LEN_SHORT_VAL = 2 * 9 + 2;
  localparam int unsigned LEN_LONG_VAL = 2 * 13 + 2;
  localparam logic [7:0] LEN_SHORT = 8'(LEN_SHORT_VAL);
  localparam logic [7:0] LEN_LONG = 8'(LEN_LONG_VAL);
  localparam int unsigned WORD_COUNT = 12;

  // Byte positions within a frame.
  localparam int unsigned POS_WIDTH = 5;
  localparam logic [POS_WIDTH-1:0] POS_START_A = 5'd0;
  localparam logic [POS_WIDTH-1:0] POS_START_B = 5'd1;
  localparam logic [POS_WIDTH-1:0] POS_LEN_HI = 5'd2;
  localparam logic [POS_WIDTH-1:0] POS_LEN_LO = 5'd3;
  localparam logic [POS_WIDTH-1:0] POS_PAYLOAD = 5'd4;
  localparam logic [POS_WIDTH-1:0] POS_CHK_HI_SHORT = 5'(LEN_SHORT_VAL + 2);
  localparam logic [POS_WIDTH-1:0] POS_CHK_HI_LONG = 5'(LEN_LONG_VAL + 2);

  typedef struct packed {
    logic [15:0] pm1_std;
    logic [15:0] pm25_std;
    logic [15:0] pm10_std;
    logic [15:0] pm1_atm;
    logic [15:0] pm25_atm;
    logic [15:0] pm10_atm;
    logic [15:0] count_03;
    logic [15:0] count_05;
    logic [15:0] count_10;
    logic [15:0] count_25;
    logic [15:0] count_50;
    logic [15:0] count_100;
  } result_t;

  typedef struct packed {
    logic    hit;
    result_t words;
  } parse_out_t;

endpackage

// ===== hdl/psfp_if.sv =====
// Stream interfaces for the received bytes and the decoded results.
interface psfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface psfp_result_if;
  logic              valid;
  logic              ready;
  psfp_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/particle_sensor_frame_parser.sv =====
// Top level of the particle sensor serial frame parser.
//
// Bytes from the sensor's serial link arrive on the rx channel, one per
// transaction. The parser hunts for the start pair 0x42 0x4D, checks the
// big-endian frame length (20 or 28), stores the first PAYLOAD_BYTES payload
// bytes and keeps a 16-bit running sum of everything before the checksum.
// When the trailing checksum matches, one transaction on the res channel
// carries twelve big-endian words from payload bytes 0 to 23, of which a short
// frame renews 0 to 17. A bad start, length or checksum silently resumes hunting.
//
// Each byte goes through an input register and then the combinational parse
// logic into the result register, so res.valid rises when the last checksum
// byte moves from the input register into the parser. One byte is accepted
// every cycle while the receiver keeps up.
// Reset clears the frame position, sums and the payload store at once.
// While a result waits on a stalled receiver the input register still takes
// one more byte; after that rx.ready drops until the result is taken.
module particle_sensor_frame_parser #(
  parameter int unsigned PAYLOAD_BYTES = 24
) (
  input  logic          clk,
  input  logic          rst,
  psfp_byte_if.sink     rx,
  psfp_result_if.source res
);

  logic                 byte_valid;
  logic [7:0]           byte_data;
  logic                 out_free;
  logic                 advance;
  psfp_pkg::parse_out_t parse_out;

  // The registered byte moves into the parser whenever the result register
  // can take whatever that byte produces.
  assign advance = byte_valid && out_free;

  psfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  psfp_parser #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .byte_data (byte_data),
    .parse_out (parse_out)
  );

  psfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .parse_out (parse_out),
    .out_free  (out_free),
    .res       (res)
  );

  // A byte held by a stalled parser stays in the input register unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !out_free) |=> (byte_valid && $stable(byte_data)))
    else $error("input register lost a stalled byte");

  // A new result only shows up after the parser found a checksum match.
  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(parse_out.hit))
    else $error("result appeared without a checksum match");

endmodule

// ===== hdl/psfp_in_reg.sv =====
// Input register stage holding one received byte.
module psfp_in_reg (
  input  logic       clk,
  input  logic       rst,
  psfp_byte_if.sink  rx,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  assign rx.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_data <= rx.rx_byte;
    end
  end

endmodule

// ===== hdl/psfp_parser.sv =====
// Frame position tracking, checksum, payload store and result decode.
module psfp_parser #(
  parameter int unsigned PAYLOAD_BYTES = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           byte_data,
  output psfp_pkg::parse_out_t parse_out
);

  localparam int unsigned AW = $clog2(PAYLOAD_BYTES);
  localparam int unsigned PW = psfp_pkg::POS_WIDTH;

  logic [PW-1:0] pos, pos_next;
  logic [15:0]   running_sum, running_sum_next;
  logic [7:0]    len_hi, len_hi_next;
  logic          is_long, is_long_next;
  logic [7:0]    chk_hi, chk_hi_next;
  logic [7:0]    store [PAYLOAD_BYTES];

  logic [PW-1:0] chk_pos;
  logic [PW-1:0] idx;
  logic          store_we;
  logic          hit;
  logic [15:0]   words [psfp_pkg::WORD_COUNT];

  assign chk_pos = is_long ? psfp_pkg::POS_CHK_HI_LONG : psfp_pkg::POS_CHK_HI_SHORT;
  assign idx = pos - psfp_pkg::POS_PAYLOAD;

  always_comb begin
    pos_next = pos + 1'b1;
    running_sum_next = running_sum + 16'(byte_data);
    len_hi_next = len_hi;
    is_long_next = is_long;
    chk_hi_next = chk_hi;
    store_we = 1'b0;
    hit = 1'b0;
    case (pos)
      psfp_pkg::POS_START_A: begin
        running_sum_next = 16'(byte_data);
        if (byte_data != psfp_pkg::START_BYTE_A) begin
          pos_next = psfp_pkg::POS_START_A;
          running_sum_next = running_sum;
        end
      end
      psfp_pkg::POS_START_B: begin
        if (byte_data != psfp_pkg::START_BYTE_B) begin
          pos_next = psfp_pkg::POS_START_A;
          running_sum_next = running_sum;
        end
      end
      psfp_pkg::POS_LEN_HI: begin
        len_hi_next = byte_data;
      end
      psfp_pkg::POS_LEN_LO: begin
        // The length is valid only with a zero high byte.
        is_long_next = (byte_data == psfp_pkg::LEN_LONG);
        if (len_hi != 8'd0 ||
            (byte_data != psfp_pkg::LEN_SHORT && byte_data != psfp_pkg::LEN_LONG)) begin
          pos_next = psfp_pkg::POS_START_A;
          running_sum_next = running_sum;
          is_long_next = is_long;
        end
      end
      default: begin
        if (pos == chk_pos) begin
          chk_hi_next = byte_data;
          running_sum_next = running_sum;
        end else if (pos == chk_pos + 1'b1) begin
          pos_next = psfp_pkg::POS_START_A;
          running_sum_next = running_sum;
          hit = (running_sum == {chk_hi, byte_data});
        end else begin
          store_we = (6'(idx) < 6'(PAYLOAD_BYTES));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= psfp_pkg::POS_START_A;
      running_sum <= 16'd0;
      len_hi <= 8'd0;
      is_long <= 1'b0;
      chk_hi <= 8'd0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        store[i] <= 8'd0;
      end
    end else if (advance) begin
      pos <= pos_next;
      running_sum <= running_sum_next;
      len_hi <= len_hi_next;
      is_long <= is_long_next;
      chk_hi <= chk_hi_next;
      if (store_we) begin
        store[idx[AW-1:0]] <= byte_data;
      end
    end
  end

  for (genvar k = 0; k < psfp_pkg::WORD_COUNT; k++) begin : g_word
    assign words[k] = {store[2*k], store[2*k+1]};
  end

  assign parse_out.hit = advance && hit;
  assign parse_out.words.pm1_std = words[0];
  assign parse_out.words.pm25_std = words[1];
  assign parse_out.words.pm10_std = words[2];
  assign parse_out.words.pm1_atm = words[3];
  assign parse_out.words.pm25_atm = words[4];
  assign parse_out.words.pm10_atm = words[5];
  assign parse_out.words.count_03 = words[6];
  assign parse_out.words.count_05 = words[7];
  assign parse_out.words.count_10 = words[8];
  assign parse_out.words.count_25 = words[9];
  assign parse_out.words.count_50 = words[10];
  assign parse_out.words.count_100 = words[11];

  // A match can only come on the low checksum byte of a short or long frame.
  a_hit_at_checksum: assert property (@(posedge clk) disable iff (rst)
    parse_out.hit |-> (pos == psfp_pkg::POS_CHK_HI_SHORT + 1'b1 ||
                       pos == psfp_pkg::POS_CHK_HI_LONG + 1'b1))
    else $error("result produced away from the checksum byte");

  // A wrong first start byte keeps the parser hunting.
  a_hunt_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && pos == psfp_pkg::POS_START_A && byte_data != psfp_pkg::START_BYTE_A)
      |=> pos == psfp_pkg::POS_START_A)
    else $error("parser left hunting without a start byte");

endmodule

// ===== hdl/psfp_out_reg.sv =====
// Result register that holds a decoded frame until it is taken.
module psfp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  psfp_pkg::parse_out_t parse_out,
  output logic                 out_free,
  psfp_result_if.source        res
);

  assign out_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= parse_out.hit;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && parse_out.hit) begin
      res.data <= parse_out.words;
    end
  end

endmodule
